// ===== rtl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the temporal pixel smoother.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int PIX_W  = 8;
  localparam int TH_W   = 9;
  localparam int TV_W   = 17;
  localparam int TI_W   = 11;
  localparam int RAD_W  = 3;
  localparam int FRM_W  = 5;
  localparam int TO_W   = 4;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 17;
  localparam int PORT_FRAMES = 15;

  // request layout, lowest bit first
  localparam int IN_TDATA_W = 280;
  localparam int IN_TUSER_W = 3;
  localparam int TI_LSB   = 0;
  localparam int TV_LSB   = 11;
  localparam int SRC_LSB  = 28;
  localparam int PF_LSB   = 148;
  localparam int FROM_LSB = 268;
  localparam int TO_LSB   = 273;

  localparam logic       OP_TABLE_WR = 1'b0;
  localparam logic       OP_FILTER   = 1'b1;
  localparam logic [1:0] PLANE_Y     = 2'd0;
  localparam logic [1:0] PLANE_U     = 2'd1;
  localparam logic [1:0] PLANE_V     = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_RADIUS   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_THRESH_Y = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_THRESH_U = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_THRESH_V = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_CENTER_W = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_DIFF_IDX = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_CRESID   = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE, S_LANE, S_WALK, S_RESID, S_SUM, S_DIV, S_OUT
  } state_t;

endpackage

// ===== rtl/tps_lane.sv =====
// ----------------------------------------------------------------------------
// tps_lane
// One walk step: threshold checks against centre and previous neighbour,
// and the weight table index of the step.
// ----------------------------------------------------------------------------
module tps_lane (
  input  logic [tps_pkg::PIX_W-1:0] pf_c,
  input  logic [tps_pkg::PIX_W-1:0] pf_t,
  input  logic [tps_pkg::PIX_W-1:0] pf_p,
  input  logic [tps_pkg::TH_W-1:0]  th,
  input  logic                      first,
  input  logic                      en,
  input  logic                      diff_idx,
  input  logic [2:0]                step_m1,
  input  logic [tps_pkg::TI_W-1:0]  frm_ti,
  output logic                      ok,
  output logic [tps_pkg::TI_W-1:0]  ti
);
  import tps_pkg::*;

  logic [PIX_W-1:0] d_c;
  logic [PIX_W-1:0] d_p;

  assign d_c = (pf_c > pf_t) ? pf_c - pf_t : pf_t - pf_c;
  assign d_p = (pf_p > pf_t) ? pf_p - pf_t : pf_t - pf_p;
  assign ok  = en && ({1'b0, d_c} < th) && (first || ({1'b0, d_p} < th));
  assign ti  = diff_idx ? {step_m1, d_c} : frm_ti;

endmodule

// ===== rtl/tps_wtab.sv =====
// ----------------------------------------------------------------------------
// tps_wtab
// Weight table memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module tps_wtab #(
  parameter int DEPTH = 5376,
  parameter int AW    = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [tps_pkg::TV_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [tps_pkg::TV_W-1:0] rdata
);
  import tps_pkg::*;

  logic [TV_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tps_div.sv =====
// ----------------------------------------------------------------------------
// tps_div
// Restoring divider, one quotient bit per cycle, quotient below 2**QW.
// ----------------------------------------------------------------------------
module tps_div #(
  parameter int NW = 30,
  parameter int DW = 22,
  parameter int QW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);
  import tps_pkg::*;

  localparam int SW = NW + QW;
  localparam int CW = $clog2(QW + 1);

  logic [NW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dsh_r, dsh_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic          ge;

  assign ge = {{QW{1'b0}}, rem_r} >= dsh_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num;
      dsh_nxt = SW'(den) << (QW - 1);
      quo_nxt = '0;
      cnt_nxt = CW'(QW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r[NW-1:0];
      end
      quo_nxt = {quo_r[QW-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/temporal_pixel_smoother_top.sv =====
// ----------------------------------------------------------------------------
// temporal_pixel_smoother_top
// Edge-preserving temporal smoothing of one 8-bit pixel position.
// ----------------------------------------------------------------------------
// Input stream in_*: one request per pixel position or per weight table
// write (in_tuser opcode). Table writes return nothing.
// A filter request is checked by 2*MAX_RADIUS parallel step lanes; the
// accepted neighbours are then read from the weight table's read port
// one per cycle, multiplied and summed, at most 2*MAX_RADIUS of them.
// Residual form then passes the S_RESID and S_SUM states, mean form the
// restoring divider, which is skipped when the weight sum is zero.
// One request is worked at a time; in_tready is high while idle.
// Results sit in an output register; the next request is taken while a
// result waits, and the block only holds when a second result is ready
// before the first was taken.
// Reset (rst_n, synchronous) restores the register defaults and clears
// control; weight table contents are undefined until written.
// ----------------------------------------------------------------------------
module temporal_pixel_smoother_top #(
  parameter int MAX_RADIUS       = 7,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // table_index, table_value, src_lo, src_hi, pf_lo, pf_hi, from_limit,
  // to_limit, zero pad
  input  logic [tps_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode, plane_sel
  input  logic [tps_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // filtered_pixel
  output logic [tps_pkg::PIX_W-1:0]        out_tdata,
  input  logic                             cfg_we,
  input  logic [tps_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [tps_pkg::CFG_DW-1:0]       cfg_wdata
);
  import tps_pkg::*;

  localparam int NF     = 2 * MAX_RADIUS + 1;
  localparam int NS     = 2 * MAX_RADIUS;
  localparam int IDX_W  = $clog2(NF);
  localparam int SLOT_W = (NS > 1) ? $clog2(NS) : 1;
  localparam int PE     = 256 * MAX_RADIUS;
  localparam int DEPTH  = 3 * PE;
  localparam int AW     = $clog2(DEPTH);
  localparam int WS_W   = TV_W + $clog2(NS + 1);
  localparam int PS_W   = WS_W + PIX_W;
  localparam int DW_W   = ((WEIGHT_FRAC_BITS + 2) > (WS_W + 1)) ?
                          (WEIGHT_FRAC_BITS + 2) : (WS_W + 1);
  localparam int PW     = DW_W + PIX_W + 1;
  localparam int TW     = PW + 2;
  localparam int QW     = 9;
  localparam logic [DW_W-1:0] ONE_V  = DW_W'(1) << WEIGHT_FRAC_BITS;
  localparam logic [TW-1:0]   HALF_V = TW'(1) << (WEIGHT_FRAC_BITS - 1);

  // configuration
  logic [RAD_W-1:0] radius_r;
  logic [TH_W-1:0]  th_y_r, th_u_r, th_v_r;
  logic [TV_W-1:0]  cw_r;
  logic             di_r, cr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(3);
      th_y_r   <= TH_W'(4);
      th_u_r   <= TH_W'(5);
      th_v_r   <= TH_W'(5);
      cw_r     <= TV_W'(21845);
      di_r     <= 1'b1;
      cr_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RADIUS:   radius_r <= cfg_wdata[RAD_W-1:0];
        CFG_THRESH_Y: th_y_r   <= cfg_wdata[TH_W-1:0];
        CFG_THRESH_U: th_u_r   <= cfg_wdata[TH_W-1:0];
        CFG_THRESH_V: th_v_r   <= cfg_wdata[TH_W-1:0];
        CFG_CENTER_W: cw_r     <= cfg_wdata[TV_W-1:0];
        CFG_DIFF_IDX: di_r     <= cfg_wdata[0];
        CFG_CRESID:   cr_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // request decode
  logic       in_acc, is_filt, is_wr;
  logic [1:0] plane_in;
  logic [TI_W-1:0] ti_in;

  assign plane_in = in_tuser[2:1];
  assign ti_in    = in_tdata[TI_LSB +: TI_W];
  assign in_acc   = in_tvalid && in_tready;
  assign is_filt  = in_acc && (in_tuser[0] == OP_FILTER) && (plane_in != 2'd3);
  assign is_wr    = in_acc && (in_tuser[0] == OP_TABLE_WR) && (plane_in != 2'd3) &&
                    ({1'b0, ti_in} < (TI_W + 1)'(PE));

  // request registers
  logic [PIX_W-1:0] src_b_r [NF];
  logic [PIX_W-1:0] pf_b_r  [NF];
  logic [1:0]       plane_r;
  logic signed [FRM_W-1:0] from_r;
  logic [TO_W-1:0]  to_r;
  logic [TH_W-1:0]  th_r;
  logic [RAD_W-1:0] r_r;
  logic [RAD_W-1:0] r_eff;

  always_comb begin
    r_eff = radius_r;
    if (radius_r == '0) begin
      r_eff = RAD_W'(1);
    end else if ({1'b0, radius_r} > (RAD_W + 1)'(MAX_RADIUS)) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end
  end

  always_ff @(posedge clk) begin
    if (is_filt) begin
      for (int j = 0; j < NF; j++) begin
        src_b_r[j] <= in_tdata[SRC_LSB + PIX_W * j +: PIX_W];
        pf_b_r[j]  <= in_tdata[PF_LSB + PIX_W * j +: PIX_W];
      end
      plane_r <= plane_in;
      from_r  <= $signed(in_tdata[FROM_LSB +: FRM_W]);
      to_r    <= in_tdata[TO_LSB +: TO_W];
      r_r     <= r_eff;
      case (plane_in)
        PLANE_Y: th_r <= th_y_r;
        PLANE_U: th_r <= th_u_r;
        default: th_r <= th_v_r;
      endcase
    end
  end

  // step lanes
  logic [IDX_W-1:0] ctr_idx;
  logic [PIX_W-1:0] c_pf, c_src;
  logic [PIX_W-1:0] tgt_pf  [NS];
  logic [PIX_W-1:0] tgt_src [NS];
  logic [TI_W-1:0]  lane_ti [NS];
  logic [NS-1:0]    lane_ok;

  assign ctr_idx = IDX_W'(r_r);
  assign c_pf    = pf_b_r[ctr_idx];
  assign c_src   = src_b_r[ctr_idx];

  for (genvar s = 0; s < NS; s++) begin : g_lane
    localparam bit BACK = (s < MAX_RADIUS);
    localparam int K    = BACK ? s + 1 : s - MAX_RADIUS + 1;
    logic             kin, lim_ok;
    logic [IDX_W-1:0] idx, sidx;
    logic [PIX_W-1:0] prev;

    assign kin  = ({1'b0, r_r} >= (RAD_W + 1)'(K));
    assign idx  = BACK ? ctr_idx - IDX_W'(K) : ctr_idx + IDX_W'(K);
    assign sidx = kin ? idx : ctr_idx;
    assign lim_ok = BACK ? ($signed({1'b0, sidx}) > from_r) : ({1'b0, sidx} < {1'b0, to_r});
    assign tgt_pf[s]  = pf_b_r[sidx];
    assign tgt_src[s] = src_b_r[sidx];
    if (K == 1) begin : g_first
      assign prev = c_pf;
    end else begin : g_next
      assign prev = tgt_pf[s-1];
    end

    tps_lane u_lane (
      .pf_c     (c_pf),
      .pf_t     (tgt_pf[s]),
      .pf_p     (prev),
      .th       (th_r),
      .first    (K == 1),
      .en       (kin && lim_ok),
      .diff_idx (di_r),
      .step_m1  (3'(K - 1)),
      .frm_ti   (TI_W'(sidx)),
      .ok       (lane_ok[s]),
      .ti       (lane_ti[s])
    );
  end

  // merge: consecutive accepted steps from the centre outward
  logic [NS-1:0] run_mask;

  always_comb begin
    logic run_b, run_f;
    run_b = 1'b1;
    run_f = 1'b1;
    for (int k = 0; k < MAX_RADIUS; k++) begin
      run_b = run_b && lane_ok[k];
      run_f = run_f && lane_ok[MAX_RADIUS + k];
      run_mask[k]              = run_b;
      run_mask[MAX_RADIUS + k] = run_f;
    end
  end

  // FSM
  state_t state_r, state_nxt;
  logic   div_start, div_done;
  logic   load_out;
  logic   walk_done;
  logic [NS-1:0]   pend_r, pend_nxt;
  logic [SLOT_W-1:0] pick;
  logic            v1_r, v2_r;
  logic [WS_W-1:0] wsum_r;
  logic [PS_W-1:0] psum_r;
  logic [QW-1:0]   div_q;

  assign walk_done = (pend_r == '0) && !v1_r && !v2_r;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (is_filt) begin
          state_nxt = S_LANE;
        end
      end
      S_LANE: state_nxt = S_WALK;
      S_WALK: begin
        if (walk_done) begin
          if (cr_r) begin
            state_nxt = S_RESID;
          end else if (wsum_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_RESID: state_nxt = S_SUM;
      S_SUM:   state_nxt = S_OUT;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_tvalid || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // table walk
  logic [TI_W-1:0]  ti_r  [NS];
  logic [PIX_W-1:0] spx_r [NS];
  logic [PIX_W-1:0] pix1_r;
  logic [TV_W-1:0]  rdata;
  logic [TV_W-1:0]  w2_r;
  logic [TV_W+PIX_W-1:0] prod_r;
  logic             rd_en;
  logic [AW-1:0]    raddr, waddr;

  always_comb begin
    logic found;
    found = 1'b0;
    pick  = '0;
    for (int s = 0; s < NS; s++) begin
      if (pend_r[s] && !found) begin
        pick  = SLOT_W'(s);
        found = 1'b1;
      end
    end
  end

  assign rd_en = (state_r == S_WALK) && (pend_r != '0);
  assign raddr = AW'(plane_r) * AW'(PE) + AW'(ti_r[pick]);
  assign waddr = AW'(plane_in) * AW'(PE) + AW'(ti_in);

  always_comb begin
    pend_nxt = pend_r;
    if (state_r == S_LANE) begin
      pend_nxt = run_mask;
    end else if (rd_en) begin
      pend_nxt = pend_r & ~(NS'(1) << pick);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      v1_r   <= rd_en;
      v2_r   <= v1_r;
    end
    if (state_r == S_LANE) begin
      for (int s = 0; s < NS; s++) begin
        ti_r[s]  <= lane_ti[s];
        spx_r[s] <= tgt_src[s];
      end
    end
    pix1_r <= spx_r[pick];
    w2_r   <= rdata;
    prod_r <= rdata * (TV_W + PIX_W)'(pix1_r);
  end

  tps_wtab #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_wtab (
    .clk   (clk),
    .we    (is_wr),
    .waddr (waddr),
    .wdata (in_tdata[TV_LSB +: TV_W]),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // accumulation
  logic [PIX_W-1:0] csrc_r;

  always_ff @(posedge clk) begin
    if (state_r == S_LANE) begin
      wsum_r <= WS_W'(cw_r);
      psum_r <= PS_W'(cw_r) * PS_W'(c_src);
      csrc_r <= c_src;
    end else if (v2_r) begin
      wsum_r <= wsum_r + WS_W'(w2_r);
      psum_r <= psum_r + PS_W'(prod_r);
    end
  end

  // residual form
  logic signed [PW-1:0] cprod_r;
  logic signed [PW-1:0] omw;
  logic signed [TW-1:0] tsum;
  logic [TW-1:0]        tsh;

  assign omw  = $signed(PW'(ONE_V)) - $signed(PW'(wsum_r));
  assign tsum = TW'(cprod_r) + $signed(TW'(psum_r)) + $signed(HALF_V);
  assign tsh  = TW'(tsum) >> WEIGHT_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (state_r == S_RESID) begin
      cprod_r <= $signed(PW'(csrc_r)) * omw;
    end
  end

  // mean form
  tps_div #(
    .NW (PS_W + 1),
    .DW (WS_W + 1),
    .QW (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({psum_r, 1'b0} + (PS_W + 1)'(wsum_r)),
    .den   ({wsum_r, 1'b0}),
    .done  (div_done),
    .quo   (div_q)
  );

  // result and output register
  logic [PIX_W-1:0] res_r;
  logic             out_v_r;
  logic [PIX_W-1:0] out_d_r;

  always_ff @(posedge clk) begin
    if (state_r == S_WALK) begin
      res_r <= '0;
    end else if (state_r == S_SUM) begin
      if (tsum < 0) begin
        res_r <= '0;
      end else if (tsh > TW'(255)) begin
        res_r <= 8'd255;
      end else begin
        res_r <= tsh[PIX_W-1:0];
      end
    end else if (div_done) begin
      res_r <= (div_q > QW'(255)) ? 8'd255 : div_q[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (load_out) begin
      out_d_r <= res_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!v1_r && !v2_r && !rd_en))
    else $error("table read pipe busy while idle");

  a_div_mode: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (!cr_r && wsum_r != '0))
    else $error("divider started outside mean form");

  a_filt_lane: assert property (@(posedge clk) disable iff (!rst_n)
    is_filt |=> (state_r == S_LANE))
    else $error("filter request not taken to lanes");

  a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> ($countones(pend_r) == $countones($past(pend_r)) - 1))
    else $error("walk did not retire exactly one step");

endmodule
